// ===== hdl/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants of the feeder step sequencer
// Item, result, register and state layouts, command and register codes.
// ----------------------------------------------------------------------------
package fss_pkg;

  // Command codes carried by the cmd field
  localparam logic [1:0] CMD_SPEED_RUN = 2'd0;
  localparam logic [1:0] CMD_ONCE      = 2'd1;
  localparam logic [1:0] CMD_BURST     = 2'd2;
  localparam logic [1:0] CMD_STOP      = 2'd3;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_JAM_BACKOFF = 3'd0;
  localparam logic [2:0] CFG_SLOT_ANGLE  = 3'd1;
  localparam logic [2:0] CFG_STEP_DELAY  = 3'd2;
  localparam logic [2:0] CFG_HOLD_TO_AUTO = 3'd3;
  localparam logic [2:0] CFG_BURST_STEPS = 3'd4;
  localparam logic [2:0] CFG_RUN_SPEED   = 3'd5;
  localparam logic [2:0] CFG_FEED_DIR    = 3'd6;

  // Drive command kinds
  localparam logic DRIVE_ANGLE = 1'b0;
  localparam logic DRIVE_SPEED = 1'b1;

  // Register reset values
  localparam logic [15:0] RST_JAM_BACKOFF  = 16'd960;
  localparam logic [12:0] RST_SLOT_ANGLE   = 13'd720;
  localparam logic [15:0] RST_STEP_DELAY   = 16'd50;
  localparam logic [15:0] RST_HOLD_TO_AUTO = 16'd300;
  localparam logic [7:0]  RST_BURST_STEPS  = 8'd3;
  localparam logic [15:0] RST_RUN_SPEED    = 16'd0;
  localparam logic [1:0]  RST_FEED_DIR     = 2'sd1;

  // Steps added per tick in free-fire, and back-off arrival window
  localparam logic [9:0]  FREEFIRE_ADD = 10'd500;
  localparam logic [32:0] JAM_TOL      = 33'd48;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               trigger;
    logic signed [31:0] real_angle;
    logic               jam_flag;
    logic signed [1:0]  speed_sign;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic [15:0]        jam_backoff_angle;
    logic [12:0]        slot_angle;
    logic [15:0]        step_delay_ms;
    logic [15:0]        hold_to_auto_ms;
    logic [7:0]         burst_steps;
    logic signed [15:0] run_speed;
    logic signed [1:0]  feed_direction;
  } cfg_t;

  typedef struct packed {
    logic        jam_handling;
    logic [31:0] soft_target;
    logic [31:0] last_step_ms;
    logic        hold_active;
    logic [31:0] hold_start_ms;
    logic        once_done;
    logic        burst_done;
  } state_t;

  typedef struct packed {
    logic               drive_kind;
    logic signed [31:0] drive_value;
    logic               jam_active;
    logic [15:0]        steps_pending;
  } res_t;

endpackage

// ===== hdl/fss_step_logic.sv =====
// ----------------------------------------------------------------------------
// fss_step_logic: next-state and drive command for one control tick
// Mode handling, step pacing, saturating step count and jam back-off.
// ----------------------------------------------------------------------------
module fss_step_logic #(
  parameter int STEP_COUNT_WIDTH = 16
) (
  input  fss_pkg::item_t               item,
  input  fss_pkg::cfg_t                cfg,
  input  fss_pkg::state_t              st,
  input  logic [STEP_COUNT_WIDTH-1:0]  steps,
  output fss_pkg::state_t              st_nxt,
  output logic [STEP_COUNT_WIDTH-1:0]  steps_nxt,
  output fss_pkg::res_t                res
);

  localparam int SUM_W = STEP_COUNT_WIDTH + 10;

  logic signed [32:0]          diff;
  logic [32:0]                 abs_gap;
  logic [34:0]                 abs_gap3;
  logic                        near_jam;
  logic                        near_slot;
  logic                        delay_ok;
  logic [31:0]                 backoff32;
  logic [31:0]                 slot32;
  logic [31:0]                 jam_target;
  logic                        jam_taken;
  logic                        jh_react;
  logic [31:0]                 st_react;
  logic [31:0]                 hold_start;
  logic                        do_add;
  logic                        clr_steps;
  logic                        run_loc;
  logic                        angle_out;
  logic [9:0]                  addend;
  logic [SUM_W-1:0]            sum;
  logic [STEP_COUNT_WIDTH-1:0] steps_mid;
  logic [31:0]                 steps_ext;

  // Distance between rotor and target, signed 32-bit interpretation
  always_comb begin
    diff     = $signed({item.real_angle[31], item.real_angle})
             - $signed({st.soft_target[31], st.soft_target});
    abs_gap  = diff[32] ? 33'(-diff) : 33'(diff);
    abs_gap3 = {2'b00, abs_gap} + {1'b0, abs_gap, 1'b0};
    near_jam  = (abs_gap <= fss_pkg::JAM_TOL);
    near_slot = (abs_gap3 <= {22'd0, cfg.slot_angle});
    delay_ok  = ((item.now_ms - st.last_step_ms) > {16'd0, cfg.step_delay_ms});
  end

  // Jam reaction: back off against the speed sign, or finish the back-off
  always_comb begin
    backoff32 = {16'd0, cfg.jam_backoff_angle};
    slot32    = {19'd0, cfg.slot_angle};
    if (item.speed_sign == 2'sd1) begin
      jam_target = 32'(item.real_angle) - backoff32;
    end else if (item.speed_sign[1]) begin
      jam_target = 32'(item.real_angle) + backoff32;
    end else begin
      jam_target = 32'(item.real_angle);
    end
    jam_taken = item.jam_flag || st.jam_handling;
    if (item.jam_flag) begin
      jh_react = !st.jam_handling;
      st_react = st.jam_handling ? st.soft_target : jam_target;
    end else begin
      jh_react = st.jam_handling && !near_jam;
      st_react = st.soft_target;
    end
  end

  always_comb begin
    st_nxt     = st;
    do_add     = 1'b0;
    clr_steps  = 1'b0;
    run_loc    = 1'b0;
    angle_out  = 1'b0;
    addend     = '0;
    hold_start = st.hold_start_ms;
    res.drive_kind  = fss_pkg::DRIVE_ANGLE;
    res.drive_value = '0;

    case (item.cmd)
      fss_pkg::CMD_SPEED_RUN: begin
        st_nxt.jam_handling = jh_react;
        if (jam_taken) begin
          res.drive_value = $signed(st_react);
        end else begin
          res.drive_kind  = fss_pkg::DRIVE_SPEED;
          res.drive_value = 32'(cfg.run_speed);
        end
        st_nxt.soft_target = 32'(item.real_angle);
      end
      fss_pkg::CMD_ONCE: begin
        angle_out          = 1'b1;
        st_nxt.hold_active = item.trigger;
        if (item.trigger) begin
          if (!st.hold_active) begin
            hold_start = item.now_ms;
          end
          st_nxt.hold_start_ms = hold_start;
          run_loc = 1'b1;
          if ((item.now_ms - hold_start) > {16'd0, cfg.hold_to_auto_ms}) begin
            do_add = 1'b1;
            addend = fss_pkg::FREEFIRE_ADD;
          end else if (!st.once_done) begin
            do_add = 1'b1;
            addend = 10'd1;
            st_nxt.once_done = 1'b1;
          end
        end else begin
          st_nxt.once_done = 1'b0;
          clr_steps = 1'b1;
        end
      end
      fss_pkg::CMD_BURST: begin
        angle_out = 1'b1;
        if (item.trigger) begin
          run_loc = 1'b1;
          if (!st.burst_done) begin
            do_add = 1'b1;
            addend = {2'b00, cfg.burst_steps};
            st_nxt.burst_done = 1'b1;
          end
        end else begin
          st_nxt.burst_done = 1'b0;
          clr_steps = 1'b1;
        end
      end
      default: begin
        res.drive_kind  = fss_pkg::DRIVE_SPEED;
        res.drive_value = '0;
      end
    endcase

    // Saturating add of new steps, or clear on trigger release
    sum = {10'd0, steps} + SUM_W'(addend);
    if (clr_steps) begin
      steps_mid = '0;
    end else if (do_add) begin
      steps_mid = (|sum[SUM_W-1:STEP_COUNT_WIDTH]) ? '1 : sum[STEP_COUNT_WIDTH-1:0];
    end else begin
      steps_mid = steps;
    end
    steps_nxt = steps_mid;

    // Angle-mode step: jam handling wins, else advance one slot on arrival
    if (run_loc) begin
      st_nxt.jam_handling = jh_react;
      if (jam_taken) begin
        st_nxt.soft_target = st_react;
      end else if (near_slot && delay_ok && (steps_mid != '0)) begin
        if (cfg.feed_direction == 2'sd1) begin
          st_nxt.soft_target = st.soft_target + slot32;
        end else if (cfg.feed_direction[1]) begin
          st_nxt.soft_target = st.soft_target - slot32;
        end
        steps_nxt           = steps_mid - STEP_COUNT_WIDTH'(1);
        st_nxt.last_step_ms = item.now_ms;
      end
    end

    if (angle_out) begin
      res.drive_value = $signed(st_nxt.soft_target);
    end

    steps_ext         = 32'(steps_nxt);
    res.jam_active    = st_nxt.jam_handling;
    res.steps_pending = (|steps_ext[31:16]) ? 16'hFFFF : steps_ext[15:0];
  end

endmodule

// ===== hdl/feeder_step_sequencer_with_jam_backoff_top.sv =====
// ----------------------------------------------------------------------------
// feeder_step_sequencer_with_jam_backoff_top: feeder drive command sequencer
// Turns one control tick into one angle or speed command for the feed motor.
// ----------------------------------------------------------------------------
// A tick is taken into an input register, the next-state logic works on it
// combinationally against the stored state, and a result register holds the
// command until the output side takes it. One tick enters per clock while
// the output side takes each command. in_ready is high while the input
// register is empty or the result register is empty or being drained.
// Registers may be rewritten only while no tick is in flight.
module feeder_step_sequencer_with_jam_backoff_top #(
  parameter int STEP_COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  // tick input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic               in_trigger,
  input  logic signed [31:0] in_real_angle,
  input  logic               in_jam_flag,
  input  logic signed [1:0]  in_speed_sign,
  input  logic [31:0]        in_now_ms,
  // drive command output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_drive_kind,
  output logic signed [31:0] out_drive_value,
  output logic               out_jam_active,
  output logic [15:0]        out_steps_pending
);

  fss_pkg::cfg_t               cfg_r;
  fss_pkg::item_t              item_r;
  logic                        item_valid_r;
  fss_pkg::state_t             st_r;
  fss_pkg::state_t             st_nxt;
  logic [STEP_COUNT_WIDTH-1:0] steps_r;
  logic [STEP_COUNT_WIDTH-1:0] steps_nxt;
  fss_pkg::res_t               res_nxt;
  fss_pkg::res_t               res_r;
  logic                        out_valid_r;
  logic                        res_open;
  logic                        advance;

  assign res_open = !out_valid_r || out_ready;
  assign advance  = item_valid_r && res_open;
  assign in_ready = !item_valid_r || res_open;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jam_backoff_angle <= fss_pkg::RST_JAM_BACKOFF;
      cfg_r.slot_angle        <= fss_pkg::RST_SLOT_ANGLE;
      cfg_r.step_delay_ms     <= fss_pkg::RST_STEP_DELAY;
      cfg_r.hold_to_auto_ms   <= fss_pkg::RST_HOLD_TO_AUTO;
      cfg_r.burst_steps       <= fss_pkg::RST_BURST_STEPS;
      cfg_r.run_speed         <= fss_pkg::RST_RUN_SPEED;
      cfg_r.feed_direction    <= fss_pkg::RST_FEED_DIR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fss_pkg::CFG_JAM_BACKOFF:  cfg_r.jam_backoff_angle <= cfg_wdata;
        fss_pkg::CFG_SLOT_ANGLE:   cfg_r.slot_angle        <= cfg_wdata[12:0];
        fss_pkg::CFG_STEP_DELAY:   cfg_r.step_delay_ms     <= cfg_wdata;
        fss_pkg::CFG_HOLD_TO_AUTO: cfg_r.hold_to_auto_ms   <= cfg_wdata;
        fss_pkg::CFG_BURST_STEPS:  cfg_r.burst_steps       <= cfg_wdata[7:0];
        fss_pkg::CFG_RUN_SPEED:    cfg_r.run_speed         <= cfg_wdata;
        fss_pkg::CFG_FEED_DIR:     cfg_r.feed_direction    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.cmd        <= in_cmd;
      item_r.trigger    <= in_trigger;
      item_r.real_angle <= in_real_angle;
      item_r.jam_flag   <= in_jam_flag;
      item_r.speed_sign <= in_speed_sign;
      item_r.now_ms     <= in_now_ms;
    end
  end

  fss_step_logic #(
    .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
  ) u_step (
    .item      (item_r),
    .cfg       (cfg_r),
    .st        (st_r),
    .steps     (steps_r),
    .st_nxt    (st_nxt),
    .steps_nxt (steps_nxt),
    .res       (res_nxt)
  );

  // Sequencer state: commit when the tick moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      steps_r <= '0;
    end else if (advance) begin
      st_r    <= st_nxt;
      steps_r <= steps_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_open) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_kind    = res_r.drive_kind;
  assign out_drive_value   = res_r.drive_value;
  assign out_jam_active    = res_r.jam_active;
  assign out_steps_pending = res_r.steps_pending;

endmodule

// ===== hdl/fss_checker.sv =====
// ----------------------------------------------------------------------------
// fss_checker: port-level checks of the feeder step sequencer
// Flow-through and hold behavior seen on the top level's ports.
// ----------------------------------------------------------------------------
module fss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_drive_kind,
  input logic signed [31:0] out_drive_value,
  input logic               out_jam_active,
  input logic [15:0]        out_steps_pending
);

  // An empty or draining result stage never stalls the input
  a_ready_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result stage is free");

  // An accepted beat reaches the output as soon as the output can take it
  a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted beat did not reach the result register");

  // A stalled beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_drive_kind) && $stable(out_drive_value)
       && $stable(out_jam_active) && $stable(out_steps_pending)))
    else $error("result beat changed while stalled");

endmodule

bind feeder_step_sequencer_with_jam_backoff_top fss_checker u_fss_checker (.*);
